>>> design/psuv_pkg.sv
// psuv_pkg: shared widths, codes and word types for the sign / unit-vector block
// no dependencies; every design file references it by scoped names

package psuv_pkg;

	// sample widths
	localparam int SAMPLE_BITS = 32;
	localparam int REAL_W      = 33;
	localparam int IMAG_W      = 32;
	localparam int RE_MAG_W    = SAMPLE_BITS + 1;
	localparam int IM_MAG_W    = SAMPLE_BITS;

	// sum of squares and its triple
	localparam int SUM_W  = 2 * SAMPLE_BITS + 1;
	localparam int SUM3_W = SUM_W + 2;

	// root digits: one cell per bit of the 17-bit scaled root
	localparam int ROOT_W = 17;
	localparam int CELLS  = ROOT_W;
	localparam int WORK_W = SUM_W + ROOT_W + 3;

	// output formats
	localparam int                      Q15_W     = 16;
	localparam logic [Q15_W-1:0]        Q15_MAX   = 16'h7fff;
	localparam logic [ROOT_W-1:0]       ROOT_MAX  = 17'h10000;
	localparam logic signed [1:0]       SIGN_ZERO = 2'sb00;
	localparam logic signed [1:0]       SIGN_POS  = 2'sb01;
	localparam logic signed [1:0]       SIGN_NEG  = 2'sb11;

	// input word
	typedef struct packed {
		logic signed [REAL_W-1:0] real_part;
		logic signed [IMAG_W-1:0] imag_part;
		logic                     line_end;
	} psuv_in_t;

	// result word
	typedef struct packed {
		logic signed [1:0]       sign_value;
		logic signed [Q15_W-1:0] unit_real;
		logic signed [Q15_W-1:0] unit_imag;
		logic                    line_end_out;
	} psuv_out_t;

	// per-component root recurrence state
	typedef struct packed {
		logic [WORK_W-1:0] rem;
		logic [WORK_W-1:0] cand;
		logic [ROOT_W-1:0] root;
	} psuv_lane_t;

	// flags that ride along with a word
	typedef struct packed {
		logic              cmode;
		logic              zero;
		logic              re_neg;
		logic              im_neg;
		logic signed [1:0] sign_value;
		logic              line_end;
	} psuv_tag_t;

	// word passed down the cell chain
	typedef struct packed {
		psuv_lane_t         re;
		psuv_lane_t         im;
		logic [SUM_W-1:0]   sum;
		logic [SUM3_W-1:0]  sum3;
		psuv_tag_t          tag;
	} psuv_work_t;

endpackage

>>> design/psuv_front.sv
// psuv_front: magnitude, squaring and sum-of-squares stages ahead of the root chain
// depends on psuv_pkg

module psuv_front (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cmode,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  psuv_pkg::psuv_in_t    up_word,
	output logic                  dn_valid,
	input  logic                  dn_ready,
	output psuv_pkg::psuv_work_t  dn_word
);

	typedef struct packed {
		logic [psuv_pkg::RE_MAG_W-1:0] re_mag;
		logic [psuv_pkg::IM_MAG_W-1:0] im_mag;
		psuv_pkg::psuv_tag_t           tag;
	} mag_t;

	typedef struct packed {
		logic [psuv_pkg::SUM_W-1:0] re_sq;
		logic [psuv_pkg::SUM_W-1:0] im_sq;
		psuv_pkg::psuv_tag_t        tag;
	} sq_t;

	logic [psuv_pkg::RE_MAG_W-1:0]   re_raw;
	logic [psuv_pkg::IM_MAG_W-1:0]   im_raw;
	mag_t                            mag_d;
	mag_t                            mag_s1;
	sq_t                             sq_d;
	sq_t                             sq_s2;
	logic [2*psuv_pkg::RE_MAG_W-1:0] re_prod;
	logic [2*psuv_pkg::IM_MAG_W-1:0] im_prod;
	logic [psuv_pkg::SUM_W-1:0]      sum_d;
	logic [psuv_pkg::SUM3_W-1:0]     sum3_d;
	psuv_pkg::psuv_work_t            work_d;
	psuv_pkg::psuv_work_t            work_s3;
	logic                            valid_s1;
	logic                            valid_s2;
	logic                            valid_s3;
	logic                            ready_s1;
	logic                            ready_s2;
	logic                            ready_s3;

	// stage ready chain
	assign ready_s3 = !valid_s3 || dn_ready;
	assign ready_s2 = !valid_s2 || ready_s3;
	assign ready_s1 = !valid_s1 || ready_s2;
	assign up_ready = ready_s1;

	// sign and magnitude of the used sample bits
	assign re_raw = up_word.real_part[psuv_pkg::RE_MAG_W-1:0];
	assign im_raw = up_word.imag_part[psuv_pkg::IM_MAG_W-1:0];

	always_comb begin
		mag_d.tag.re_neg = re_raw[psuv_pkg::RE_MAG_W-1];
		mag_d.tag.im_neg = im_raw[psuv_pkg::IM_MAG_W-1];
		mag_d.re_mag = mag_d.tag.re_neg ? (~re_raw + psuv_pkg::RE_MAG_W'(1)) : re_raw;
		mag_d.im_mag = mag_d.tag.im_neg ? (~im_raw + psuv_pkg::IM_MAG_W'(1)) : im_raw;
		mag_d.tag.cmode = cmode;
		mag_d.tag.zero = (mag_d.re_mag == '0) && (mag_d.im_mag == '0);
		mag_d.tag.line_end = up_word.line_end;
		if (!cmode && (mag_d.re_mag != '0)) begin
			mag_d.tag.sign_value = mag_d.tag.re_neg ? psuv_pkg::SIGN_NEG : psuv_pkg::SIGN_POS;
		end else begin
			mag_d.tag.sign_value = psuv_pkg::SIGN_ZERO;
		end
	end

	// squares of both magnitudes
	assign re_prod = mag_s1.re_mag * mag_s1.re_mag;
	assign im_prod = mag_s1.im_mag * mag_s1.im_mag;

	always_comb begin
		sq_d.re_sq = re_prod[psuv_pkg::SUM_W-1:0];
		sq_d.im_sq = im_prod[psuv_pkg::SUM_W-1:0];
		sq_d.tag   = mag_s1.tag;
	end

	// sum of squares, its triple, and the starting recurrence state
	assign sum_d  = sq_s2.re_sq + sq_s2.im_sq;
	assign sum3_d = psuv_pkg::SUM3_W'(sq_s2.re_sq) + psuv_pkg::SUM3_W'({sq_s2.re_sq, 1'b0})
		+ psuv_pkg::SUM3_W'(sq_s2.im_sq) + psuv_pkg::SUM3_W'({sq_s2.im_sq, 1'b0});

	always_comb begin
		work_d.re.rem  = psuv_pkg::WORK_W'(sq_s2.re_sq);
		work_d.re.cand = psuv_pkg::WORK_W'(sum_d);
		work_d.re.root = '0;
		work_d.im.rem  = psuv_pkg::WORK_W'(sq_s2.im_sq);
		work_d.im.cand = psuv_pkg::WORK_W'(sum_d);
		work_d.im.root = '0;
		work_d.sum     = sum_d;
		work_d.sum3    = sum3_d;
		work_d.tag     = sq_s2.tag;
	end

	// stage valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (ready_s1) valid_s1 <= up_valid;
			if (ready_s2) valid_s2 <= valid_s1;
			if (ready_s3) valid_s3 <= valid_s2;
		end
	end

	// stage payloads
	always_ff @(posedge clk) begin
		if (ready_s1) mag_s1 <= mag_d;
		if (ready_s2) sq_s2 <= sq_d;
		if (ready_s3) work_s3 <= work_d;
	end

	assign dn_valid = valid_s3;
	assign dn_word  = work_s3;

endmodule

>>> design/psuv_cell.sv
// psuv_cell: one digit step of the scaled square-root ratio for both components
// depends on psuv_pkg

module psuv_cell (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  psuv_pkg::psuv_work_t  up_word,
	output logic                  dn_valid,
	input  logic                  dn_ready,
	output psuv_pkg::psuv_work_t  dn_word
);

	// trial subtract of the candidate; either digit rescales remainder and candidate
	function automatic psuv_pkg::psuv_lane_t step_lane(
		psuv_pkg::psuv_lane_t        l,
		logic [psuv_pkg::SUM_W-1:0]  s,
		logic [psuv_pkg::SUM3_W-1:0] s3
	);
		logic [psuv_pkg::WORK_W:0]   diff;
		logic [psuv_pkg::WORK_W-1:0] cand2;
		logic                        fit;
		psuv_pkg::psuv_lane_t        r;
		diff  = {1'b0, l.rem} - {1'b0, l.cand};
		fit   = !diff[psuv_pkg::WORK_W];
		cand2 = {l.cand[psuv_pkg::WORK_W-2:0], 1'b0};
		if (fit) begin
			r.rem  = {diff[psuv_pkg::WORK_W-3:0], 2'b00};
			r.cand = cand2 + psuv_pkg::WORK_W'(s3);
		end else begin
			r.rem  = {l.rem[psuv_pkg::WORK_W-3:0], 2'b00};
			r.cand = cand2 - psuv_pkg::WORK_W'(s);
		end
		r.root = {l.root[psuv_pkg::ROOT_W-2:0], fit};
		return r;
	endfunction

	psuv_pkg::psuv_work_t word_d;
	psuv_pkg::psuv_work_t word_s1;
	logic                 valid_s1;

	assign up_ready = !valid_s1 || dn_ready;

	// digit step
	always_comb begin
		word_d    = up_word;
		word_d.re = step_lane(up_word.re, up_word.sum, up_word.sum3);
		word_d.im = step_lane(up_word.im, up_word.sum, up_word.sum3);
	end

	// valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (up_ready) begin
			valid_s1 <= up_valid;
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (up_ready) word_s1 <= word_d;
	end

	assign dn_valid = valid_s1;
	assign dn_word  = word_s1;

endmodule

>>> design/psuv_back.sv
// psuv_back: rounding, sign and saturation into Q1.15, plus the output register
// depends on psuv_pkg

module psuv_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  up_valid,
	output logic                  up_ready,
	input  psuv_pkg::psuv_work_t  up_word,
	output logic                  dn_valid,
	input  logic                  dn_stall,
	output psuv_pkg::psuv_out_t   dn_word
);

	// root to rounded magnitude, then signed and saturated
	function automatic logic [psuv_pkg::Q15_W-1:0] to_q15(
		logic [psuv_pkg::ROOT_W-1:0] root,
		logic                        neg
	);
		logic [psuv_pkg::ROOT_W:0]    up;
		logic [psuv_pkg::ROOT_W-1:0]  k;
		logic [psuv_pkg::Q15_W-1:0]   r;
		up = {1'b0, root} + (psuv_pkg::ROOT_W + 1)'(1);
		k  = up[psuv_pkg::ROOT_W:1];
		if (neg) begin
			r = ~k[psuv_pkg::Q15_W-1:0] + psuv_pkg::Q15_W'(1);
		end else if (k > psuv_pkg::ROOT_W'(psuv_pkg::Q15_MAX)) begin
			r = psuv_pkg::Q15_MAX;
		end else begin
			r = k[psuv_pkg::Q15_W-1:0];
		end
		return r;
	endfunction

	psuv_pkg::psuv_out_t res_d;
	psuv_pkg::psuv_out_t res_q;
	logic                valid_q;

	assign up_ready = !valid_q || !dn_stall;

	// result word
	always_comb begin
		res_d.sign_value   = up_word.tag.sign_value;
		res_d.line_end_out = up_word.tag.line_end;
		if (up_word.tag.cmode && !up_word.tag.zero) begin
			res_d.unit_real = to_q15(up_word.re.root, up_word.tag.re_neg);
			res_d.unit_imag = to_q15(up_word.im.root, up_word.tag.im_neg);
		end else begin
			res_d.unit_real = '0;
			res_d.unit_imag = '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (up_ready) begin
			valid_q <= up_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (up_ready) res_q <= res_d;
	end

	assign dn_valid = valid_q;
	assign dn_word  = res_q;

	// scaled root of a nonzero sample never passes one
	a_root_bound: assert property (@(posedge clk) disable iff (!arst_n)
		up_valid && !up_word.tag.zero |->
			up_word.re.root <= psuv_pkg::ROOT_MAX && up_word.im.root <= psuv_pkg::ROOT_MAX)
		else $error("scaled root above one");

	// a zero sample leaves an empty remainder after the chain
	a_zero_rem: assert property (@(posedge clk) disable iff (!arst_n)
		up_valid && up_word.tag.zero |-> up_word.re.rem == '0 && up_word.im.rem == '0)
		else $error("zero sample with nonzero remainder");

endmodule

>>> design/pixel_sign_or_unit_vector.sv
// pixel_sign_or_unit_vector: sign of a real sample or unit vector of a complex sample
// path from accepted sample word to result word: 3 front stages, 17 root cells and
// 1 output register; throughput one word per cycle while no result is held by result_stall
// every stage has its own valid and takes a word when it or its successor is free
// arst_n clears all valid flags and complex_mode; payload registers are not reset
// depends on psuv_pkg, psuv_front, psuv_cell, psuv_back

module pixel_sign_or_unit_vector (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_stall,
	input  psuv_pkg::psuv_in_t   sample,
	output logic                 result_valid,
	input  logic                 result_stall,
	output psuv_pkg::psuv_out_t  result,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata
);

	logic                 mode_q;
	logic                 front_ready;
	logic                 work_valid [psuv_pkg::CELLS+1];
	logic                 work_ready [psuv_pkg::CELLS+1];
	psuv_pkg::psuv_work_t work       [psuv_pkg::CELLS+1];

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= 1'b0;
		end else if (cfg_we) begin
			mode_q <= cfg_wdata;
		end
	end

	// magnitudes and sum of squares
	psuv_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmode    (mode_q),
		.up_valid (sample_valid),
		.up_ready (front_ready),
		.up_word  (sample),
		.dn_valid (work_valid[0]),
		.dn_ready (work_ready[0]),
		.dn_word  (work[0])
	);

	assign sample_stall = !front_ready;

	// root digit chain, most significant digit first
	for (genvar i = 0; i < psuv_pkg::CELLS; i++) begin : g_cell
		psuv_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_valid (work_valid[i]),
			.up_ready (work_ready[i]),
			.up_word  (work[i]),
			.dn_valid (work_valid[i+1]),
			.dn_ready (work_ready[i+1]),
			.dn_word  (work[i+1])
		);
	end

	// rounding and output register
	psuv_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.up_valid (work_valid[psuv_pkg::CELLS]),
		.up_ready (work_ready[psuv_pkg::CELLS]),
		.up_word  (work[psuv_pkg::CELLS]),
		.dn_valid (result_valid),
		.dn_stall (result_stall),
		.dn_word  (result)
	);

	// input only backs up when a finished word is held at the output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		sample_stall |-> result_valid && result_stall)
		else $error("sample stalled without a held result");

	// a sign result carries no unit vector
	a_sign_only: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.sign_value != psuv_pkg::SIGN_ZERO |->
			result.unit_real == '0 && result.unit_imag == '0)
		else $error("sign and unit vector both present");

endmodule
